// ===== design/asob_pkg.sv =====
// Shared types and constants for the additive sine oscillator bank.
// Holds the input/output word structs and the controller/datapath command bundle.
// No dependencies.
package asob_pkg;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GEN = 1'b1;

    localparam int unsigned SINE_W       = 17;
    localparam int unsigned TGT_W        = 16;
    localparam int unsigned AMP_W        = 24;
    localparam int unsigned SMOOTH_K     = 1966;
    localparam int unsigned SMOOTH_K_W   = 12;
    localparam int unsigned FRAC_SH      = 16;
    localparam int          OUT_MAX      = 8388607;
    localparam int          OUT_MIN      = -8388608;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    typedef struct packed {
        logic        cmd;
        logic [6:0]  osc_index;
        logic [23:0] phase_step;
        logic [15:0] target_left;
        logic [15:0] target_right;
    } t_in_word;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
    } t_out_word;

    typedef struct packed {
        logic clr_wr;
        logic set_wr;
        logic rd_en;
        logic acc_clr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_empty;
    } t_dp_status;

endpackage

// ===== design/asob_dp.sv =====
// Datapath of the oscillator bank: parameter and state memories, sine table,
// interpolation, amplitude smoothing, stereo accumulators and output word.
// Depends on asob_pkg.
module asob_dp import asob_pkg::*; #(
    parameter  int NUM_OSC    = 128,
    parameter  int TABLE_LEN  = 48,
    parameter  int PHASE_BITS = 24,
    localparam int ADDR_W     = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_in_word          i_in_word,
    output t_dp_status        o_status,
    output t_out_word         o_out_word
);

    localparam int P      = PHASE_BITS;
    localparam int IDX_W  = $clog2(TABLE_LEN + 1);
    localparam int PROD_W = P + IDX_W;
    localparam int A_W    = P + 2 * TGT_W;
    localparam int B_W    = P + 2 * AMP_W;
    localparam int DK_W   = AMP_W + 1 + SMOOTH_K_W;
    localparam int Q_W    = DK_W - FRAC_SH;
    localparam int DM_W   = SINE_W + 1 + P + 1;
    localparam int PL_W   = SINE_W + AMP_W + 1;
    localparam int ACC_W  = PL_W + $clog2(NUM_OSC) + 1;
    localparam int V_W    = ACC_W - FRAC_SH;

    localparam logic signed [DK_W-1:0] SMOOTH_KD = DK_W'(SMOOTH_K);
    localparam logic signed [V_W-1:0]  V_MAX     = V_W'(OUT_MAX);
    localparam logic signed [V_W-1:0]  V_MIN     = V_W'(OUT_MIN);

    // sine table, Q2.15, last entry repeats the first
    logic signed [SINE_W-1:0] w_rom [TABLE_LEN+1];

    for (genvar k = 0; k < TABLE_LEN; k++) begin : g_rom
        localparam longint unsigned N   = 64'(TABLE_LEN);
        localparam longint unsigned M   = 64'(4 * k);
        localparam longint unsigned NUM = (M <= N) ? M :
                                          (M <= 2 * N) ? (2 * N - M) :
                                          (M <= 3 * N) ? (M - 2 * N) : (4 * N - M);
        localparam bit              NEG = (M > 2 * N);
        localparam longint unsigned X   = NUM * HALF_PI_Q30 / N;
        localparam longint unsigned X2  = (X * X) >> 30;
        localparam longint unsigned T1  = Q30_ONE - X2 / 110;
        localparam longint unsigned T2  = Q30_ONE - ((X2 * T1) >> 30) / 72;
        localparam longint unsigned T3  = Q30_ONE - ((X2 * T2) >> 30) / 42;
        localparam longint unsigned T4  = Q30_ONE - ((X2 * T3) >> 30) / 20;
        localparam longint unsigned T5  = Q30_ONE - ((X2 * T4) >> 30) / 6;
        localparam longint unsigned S   = (X * T5) >> 30;
        localparam longint unsigned Q   = (S + 64'd16384) >> 15;
        assign w_rom[k] = NEG ? -$signed(SINE_W'(Q)) : $signed(SINE_W'(Q));
    end
    assign w_rom[TABLE_LEN] = w_rom[0];

    function automatic logic signed [23:0] f_sat(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0]      biased;
        logic signed [V_W-1:0] v;
        biased = acc + (acc[ACC_W-1] ? ACC_W'(16'hFFFF) : ACC_W'(0));
        v      = biased[ACC_W-1:FRAC_SH];
        if (v > V_MAX) begin
            v = V_MAX;
        end else if (v < V_MIN) begin
            v = V_MIN;
        end
        return v[23:0];
    endfunction

    logic [A_W-1:0] r_mem_a [NUM_OSC];
    logic [B_W-1:0] r_mem_b [NUM_OSC];

    logic [A_W-1:0]    r_rd_a;
    logic [B_W-1:0]    r_rd_b;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_valid;

    logic [IDX_W-1:0]       r_s2_idx;
    logic [P-1:0]           r_s2_frac;
    logic [P-1:0]           r_s2_phase_next;
    logic [AMP_W-1:0]       r_s2_sl;
    logic [AMP_W-1:0]       r_s2_sr;
    logic signed [DK_W-1:0] r_s2_dk_l;
    logic signed [DK_W-1:0] r_s2_dk_r;
    logic [ADDR_W-1:0]      r_s2_addr;
    logic                   r_s2_valid;

    logic signed [SINE_W-1:0] r_s3_sine;
    logic [AMP_W-1:0]         r_s3_sl;
    logic [AMP_W-1:0]         r_s3_sr;
    logic                     r_s3_valid;

    logic signed [PL_W-1:0] r_s4_pl;
    logic signed [PL_W-1:0] r_s4_pr;
    logic                   r_s4_valid;

    logic signed [ACC_W-1:0] r_acc_l;
    logic signed [ACC_W-1:0] r_acc_r;
    t_out_word               r_out;

    logic              w_set_ok;
    logic [ADDR_W-1:0] w_set_addr;

    logic [P-1:0]     w_rd_step;
    logic [TGT_W-1:0] w_rd_tl;
    logic [TGT_W-1:0] w_rd_tr;
    logic [P-1:0]     w_rd_phase;
    logic [AMP_W-1:0] w_rd_sl;
    logic [AMP_W-1:0] w_rd_sr;

    logic [PROD_W-1:0]        w_prod;
    logic [IDX_W-1:0]         w_idx_raw;
    logic [IDX_W-1:0]         w_idx;
    logic signed [AMP_W:0]    w_d_l;
    logic signed [AMP_W:0]    w_d_r;
    logic signed [DK_W-1:0]   w_dk_l;
    logic signed [DK_W-1:0]   w_dk_r;

    logic signed [SINE_W-1:0] w_a;
    logic signed [SINE_W-1:0] w_b;
    logic signed [SINE_W:0]   w_diff;
    logic signed [DM_W-1:0]   w_dm;
    logic signed [SINE_W:0]   w_step;
    logic signed [SINE_W:0]   w_sine_sum;
    logic [DK_W-1:0]          w_bias_l;
    logic [DK_W-1:0]          w_bias_r;
    logic signed [Q_W-1:0]    w_q_l;
    logic signed [Q_W-1:0]    w_q_r;
    logic [AMP_W:0]           w_sum_l;
    logic [AMP_W:0]           w_sum_r;
    logic [AMP_W-1:0]         w_new_l;
    logic [AMP_W-1:0]         w_new_r;

    assign w_set_ok   = i_cmd.set_wr && (int'(i_in_word.osc_index) < NUM_OSC);
    assign w_set_addr = ADDR_W'(i_in_word.osc_index);

    // memories: parameters and targets in one, running state in the other
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem_a[i_addr] <= '0;
        end else if (w_set_ok) begin
            r_mem_a[w_set_addr] <= {P'(i_in_word.phase_step), i_in_word.target_left,
                                    i_in_word.target_right};
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem_a[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem_b[i_addr] <= '0;
        end else if (r_s2_valid) begin
            r_mem_b[r_s2_addr] <= {r_s2_phase_next, w_new_l, w_new_r};
        end
        if (i_cmd.rd_en) begin
            r_rd_b <= r_mem_b[i_addr];
        end
    end

    // stage 1: table position, phase advance, smoothing product
    assign w_rd_step  = r_rd_a[A_W-1 -: P];
    assign w_rd_tl    = r_rd_a[2*TGT_W-1 -: TGT_W];
    assign w_rd_tr    = r_rd_a[TGT_W-1:0];
    assign w_rd_phase = r_rd_b[B_W-1 -: P];
    assign w_rd_sl    = r_rd_b[2*AMP_W-1 -: AMP_W];
    assign w_rd_sr    = r_rd_b[AMP_W-1:0];

    assign w_prod    = PROD_W'(w_rd_phase) * PROD_W'(TABLE_LEN);
    assign w_idx_raw = w_prod[PROD_W-1 -: IDX_W];
    assign w_idx     = (w_idx_raw > IDX_W'(TABLE_LEN - 1)) ? IDX_W'(TABLE_LEN - 1) : w_idx_raw;

    assign w_d_l  = $signed({1'b0, w_rd_tl, (AMP_W-TGT_W)'(0)}) - $signed({1'b0, w_rd_sl});
    assign w_d_r  = $signed({1'b0, w_rd_tr, (AMP_W-TGT_W)'(0)}) - $signed({1'b0, w_rd_sr});
    assign w_dk_l = DK_W'(w_d_l) * SMOOTH_KD;
    assign w_dk_r = DK_W'(w_d_r) * SMOOTH_KD;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_addr <= i_addr;
        end
        if (r_rd_valid) begin
            r_s2_idx        <= w_idx;
            r_s2_frac       <= w_prod[P-1:0];
            r_s2_phase_next <= w_rd_phase + w_rd_step;
            r_s2_sl         <= w_rd_sl;
            r_s2_sr         <= w_rd_sr;
            r_s2_dk_l       <= w_dk_l;
            r_s2_dk_r       <= w_dk_r;
            r_s2_addr       <= r_rd_addr;
        end
    end

    // stage 2: interpolate, finish smoothing (truncate toward zero)
    assign w_a        = w_rom[r_s2_idx];
    assign w_b        = w_rom[r_s2_idx + IDX_W'(1)];
    assign w_diff     = (SINE_W+1)'(w_b) - (SINE_W+1)'(w_a);
    assign w_dm       = DM_W'(w_diff) * DM_W'($signed({1'b0, r_s2_frac}));
    assign w_step     = w_dm[P+SINE_W:P];
    assign w_sine_sum = (SINE_W+1)'(w_a) + w_step;

    assign w_bias_l = r_s2_dk_l + (r_s2_dk_l[DK_W-1] ? DK_W'(16'hFFFF) : DK_W'(0));
    assign w_bias_r = r_s2_dk_r + (r_s2_dk_r[DK_W-1] ? DK_W'(16'hFFFF) : DK_W'(0));
    assign w_q_l    = w_bias_l[DK_W-1:FRAC_SH];
    assign w_q_r    = w_bias_r[DK_W-1:FRAC_SH];
    assign w_sum_l  = {1'b0, r_s2_sl} + (AMP_W+1)'(w_q_l);
    assign w_sum_r  = {1'b0, r_s2_sr} + (AMP_W+1)'(w_q_r);
    assign w_new_l  = w_sum_l[AMP_W-1:0];
    assign w_new_r  = w_sum_r[AMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_sine <= w_sine_sum[SINE_W-1:0];
            r_s3_sl   <= w_new_l;
            r_s3_sr   <= w_new_r;
        end
        if (r_s3_valid) begin
            r_s4_pl <= PL_W'(r_s3_sine) * PL_W'($signed({1'b0, r_s3_sl}));
            r_s4_pr <= PL_W'(r_s3_sine) * PL_W'($signed({1'b0, r_s3_sr}));
        end
        if (i_cmd.acc_clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_s4_valid) begin
            r_acc_l <= r_acc_l + ACC_W'(r_s4_pl);
            r_acc_r <= r_acc_r + ACC_W'(r_s4_pr);
        end
        if (i_cmd.out_load) begin
            r_out.left_sample  <= f_sat(r_acc_l);
            r_out.right_sample <= f_sat(r_acc_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            r_s2_valid <= r_rd_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    assign o_status.pipe_empty = !(r_rd_valid || r_s2_valid || r_s3_valid || r_s4_valid);
    assign o_out_word          = r_out;

endmodule

// ===== design/asob_ctrl.sv =====
// Controller of the oscillator bank: clearing sweep, input handshake,
// oscillator sweep, drain wait and output word register handshake.
// Depends on asob_pkg.
module asob_ctrl import asob_pkg::*; #(
    parameter  int NUM_OSC = 128,
    localparam int ADDR_W  = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    input  logic              i_out_stall,
    input  t_dp_status        i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_dp_cmd           o_cmd,
    output logic [ADDR_W-1:0] o_addr
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_last;

    assign w_last = (r_addr == ADDR_W'(NUM_OSC - 1));

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (w_last) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_GEN) begin
                        o_cmd.acc_clr = 1'b1;
                        n_addr        = '0;
                        n_state       = ST_RUN;
                    end else begin
                        o_cmd.set_wr = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.rd_en = 1'b1;
                if (w_last) begin
                    n_addr  = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_addr      = r_addr;

endmodule

// ===== design/additive_sine_oscillator_bank_top.sv =====
// Additive stereo sine oscillator bank, top level; instantiates asob_ctrl and asob_dp.
// Set word: written to the parameter memory on acceptance. Generate word: one oscillator
// per cycle through a five-stage datapath, then a drain wait and the output word load.
// The next word is taken only after the output word is loaded, which waits on output stall.
// Reset: synchronous, active low; then a clearing sweep over all oscillators, input stalled.
module additive_sine_oscillator_bank_top import asob_pkg::*; #(
    parameter int NUM_OSC    = 128,
    parameter int TABLE_LEN  = 48,
    parameter int PHASE_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int ADDR_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    t_dp_cmd           w_cmd;
    t_dp_status        w_status;
    logic [ADDR_W-1:0] w_addr;

    asob_ctrl #(
        .NUM_OSC (NUM_OSC)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_word.cmd),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr)
    );

    asob_dp #(
        .NUM_OSC    (NUM_OSC),
        .TABLE_LEN  (TABLE_LEN),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_addr     (w_addr),
        .i_in_word  (i_in_word),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> w_status.pipe_empty)
        else $error("input open while datapath busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.acc_clr |=> w_cmd.rd_en)
        else $error("oscillator sweep did not start");

    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_wr |-> (o_in_stall && !w_cmd.rd_en))
        else $error("clearing sweep overlaps other work");

endmodule
